/* src/psd_pkg.sv */
// Shared types and constants for the pairwise signature difference core.
// No dependencies; imported by psd_front, psd_back, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    localparam int SIG_W     = 64;
    localparam int MASK_W    = 32;
    localparam int LABEL_W   = 3;
    localparam int CLS_W     = 2;
    localparam int IDX_W     = 6;
    localparam int POS_W     = 6;
    localparam int POS_RESET = 32;

    localparam logic [LABEL_W-1:0] LABEL_LAST_VALID = 3'd3;
    localparam logic [CLS_W-1:0]   CLS_CONFLICT     = 2'd3;

    typedef struct packed {
        logic [SIG_W-1:0]  sig;
        logic [CLS_W-1:0]  cls;
        logic [MASK_W-1:0] pos_mask;
    } cmd_t;

    function automatic logic [MASK_W-1:0] sig_diff(
        input logic [SIG_W-1:0]  a,
        input logic [SIG_W-1:0]  b,
        input logic [MASK_W-1:0] en
    );
        logic [MASK_W-1:0] m;
        m = '0;
        for (int p = 0; p < MASK_W; p++)
        begin
            m[p] = en[p] && (a[2*p +: 2] != b[2*p +: 2]);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* src/psd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/psd_queue.sv */
// Two-entry request queue between the front and back parts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psd_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic      [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = data_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* src/psd_front.sv */
// Front part: takes input rows, tracks the row count of the set, drops rows
// with invalid labels or beyond capacity, queues compare requests. Uses psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_front
    import psd_pkg::*;
#(
    parameter int MAX_ROWS      = 64,
    parameter int MAX_POSITIONS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [POS_W-1:0]            cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        first_of_set,
    input  wire logic [LABEL_W-1:0]          class_label,
    input  wire logic [SIG_W-1:0]            signature,
    input  wire logic                        q_full,
    output logic                             q_push,
    output cmd_t                             q_cmd,
    output logic      [$clog2(MAX_ROWS)-1:0] q_cur
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  rows_reg;
    logic [CNT_W-1:0]  rows_next;
    logic [CNT_W-1:0]  base;
    logic [POS_W-1:0]  pos_sat;
    logic [MASK_W-1:0] pos_mask;
    logic              accept;
    logic              keep;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign base     = first_of_set ? '0 : rows_reg;
    assign keep     = (class_label <= LABEL_LAST_VALID) && (base < CNT_W'(MAX_ROWS));
    assign q_push   = accept && keep;
    assign q_cur    = ROW_W'(base);

    assign pos_sat = (pos_reg > POS_W'(MAX_POSITIONS)) ? POS_W'(MAX_POSITIONS) : pos_reg;

    always_comb
    begin
        for (int p = 0; p < MASK_W; p++)
        begin
            pos_mask[p] = (7'(p) < {1'b0, pos_sat});
        end
    end

    assign q_cmd.sig      = signature;
    assign q_cmd.cls      = class_label[CLS_W-1:0];
    assign q_cmd.pos_mask = pos_mask;

    always_comb
    begin
        rows_next = rows_reg;
        if (accept)
        begin
            rows_next = keep ? base + CNT_W'(1) : base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_W'(POS_RESET);
            rows_reg <= '0;
        end
        else
        begin
            rows_reg <= rows_next;
            if (cfg_wr_en)
            begin
                pos_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

/* src/psd_back.sv */
// Back part: stores each request's row, scans earlier rows one per cycle unless
// the output stalls, and emits difference masks through an output register. Uses psd_pkg, psd_ram.
`timescale 1ns / 1ps
`default_nettype none

module psd_back
    import psd_pkg::*;
#(
    parameter int MAX_ROWS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  wire cmd_t                        q_cmd,
    input  wire logic [$clog2(MAX_ROWS)-1:0] q_cur,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [MASK_W-1:0]           difference_mask,
    output logic      [IDX_W-1:0]            earlier_row,
    output logic      [IDX_W-1:0]            current_row,
    output logic                             last_of_run
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int RAM_W = SIG_W + CLS_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ROW_W-1:0]  cur_reg, cur_next;
    logic [ROW_W-1:0]  a_idx_reg, a_idx_next;
    logic              b_valid_reg, b_valid_next;
    logic [ROW_W-1:0]  b_idx_reg, b_idx_next;
    logic              h_valid_reg, h_valid_next;
    logic [MASK_W-1:0] h_mask_reg, h_mask_next;
    logic [ROW_W-1:0]  h_idx_reg, h_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] out_mask_reg, out_mask_next;
    logic [IDX_W-1:0]  out_earlier_reg, out_earlier_next;
    logic [IDX_W-1:0]  out_current_reg, out_current_next;
    logic              out_last_reg, out_last_next;

    logic              ram_we;
    logic [RAM_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [RAM_W-1:0]  ram_rdata;
    logic [CLS_W-1:0]  rd_cls;
    logic [MASK_W-1:0] b_mask;
    logic              b_clash;
    logic              out_free;
    logic              b_stall;
    logic              issue;

    psd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_cur),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (a_idx_reg),
        .rdata (ram_rdata)
    );

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign ram_we    = q_pop;
    assign ram_wdata = {q_cmd.cls, q_cmd.sig};

    assign rd_cls   = ram_rdata[SIG_W +: CLS_W];
    assign b_mask   = sig_diff(ram_rdata[SIG_W-1:0], cmd_reg.sig, cmd_reg.pos_mask);
    assign b_clash  = b_valid_reg && ((rd_cls != cmd_reg.cls) ||
                      ((rd_cls == CLS_CONFLICT) && (cmd_reg.cls == CLS_CONFLICT)));
    assign out_free = !out_valid_reg || out_ready;
    assign b_stall  = b_clash && h_valid_reg && !out_free;
    assign issue    = (state_reg == ST_SCAN) && (a_idx_reg != cur_reg) && !b_stall;
    assign ram_re   = issue;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        cur_next         = cur_reg;
        a_idx_next       = a_idx_reg;
        b_valid_next     = b_valid_reg;
        b_idx_next       = b_idx_reg;
        h_valid_next     = h_valid_reg;
        h_mask_next      = h_mask_reg;
        h_idx_next       = h_idx_reg;
        out_valid_next   = out_valid_reg;
        out_mask_next    = out_mask_reg;
        out_earlier_next = out_earlier_reg;
        out_current_next = out_current_reg;
        out_last_next    = out_last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next   = q_cmd;
                    cur_next   = q_cur;
                    a_idx_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (b_clash && !b_stall)
                begin
                    if (h_valid_reg)
                    begin
                        out_valid_next   = 1'b1;
                        out_mask_next    = h_mask_reg;
                        out_earlier_next = IDX_W'(h_idx_reg);
                        out_current_next = IDX_W'(cur_reg);
                        out_last_next    = 1'b0;
                    end
                    h_valid_next = 1'b1;
                    h_mask_next  = b_mask;
                    h_idx_next   = b_idx_reg;
                end
                if (!b_stall)
                begin
                    b_valid_next = issue;
                end
                if (issue)
                begin
                    b_idx_next = a_idx_reg;
                    a_idx_next = a_idx_reg + ROW_W'(1);
                end
                if ((a_idx_reg == cur_reg) && !b_valid_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!h_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_mask_next    = h_mask_reg;
                    out_earlier_next = IDX_W'(h_idx_reg);
                    out_current_next = IDX_W'(cur_reg);
                    out_last_next    = 1'b1;
                    h_valid_next     = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            b_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            b_valid_reg   <= b_valid_next;
            h_valid_reg   <= h_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        cur_reg         <= cur_next;
        a_idx_reg       <= a_idx_next;
        b_idx_reg       <= b_idx_next;
        h_mask_reg      <= h_mask_next;
        h_idx_reg       <= h_idx_next;
        out_mask_reg    <= out_mask_next;
        out_earlier_reg <= out_earlier_next;
        out_current_reg <= out_current_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign difference_mask = out_mask_reg;
    assign earlier_row     = out_earlier_reg;
    assign current_row     = out_current_reg;
    assign last_of_run     = out_last_reg;

endmodule

`default_nettype wire

/* src/pairwise_signature_difference_core.sv */
// Top level of the pairwise signature difference core.
// Uses psd_pkg, psd_front, psd_queue, psd_back (which holds psd_ram).
//
// Input channel (in_valid/in_ready) takes one row per request: first_of_set,
// class_label, signature. Rows labelled other or with codes 5 to 7, and rows past MAX_ROWS in a set,
// are taken and dropped. Every kept row is stored and compared with the earlier
// rows of its set; each incompatible pair gives one request on the output
// channel (out_valid/out_ready) with its difference mask and row indices, the
// last one of the row flagged by last_of_run.
// The back part's scan reads one stored row per cycle from a RAM unless the output
// stalls; the back part pops the next request only when its current scan is done.
// A two-entry queue lets the input take rows while the back part is busy or
// the receiver stalls; a stalled output holds the scan in place.
// cfg_wr_en/cfg_wr_data write positions_in_use (reset 32).
// Reset clears the row count, the queue and all valid flags; the row RAM
// needs no clearing, as only rows of the current set are read.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_signature_difference_core
    import psd_pkg::*;
#(
    parameter int MAX_ROWS      = 64,
    parameter int MAX_POSITIONS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [POS_W-1:0]   cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               first_of_set,
    input  wire logic [LABEL_W-1:0] class_label,
    input  wire logic [SIG_W-1:0]   signature,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [MASK_W-1:0]  difference_mask,
    output logic      [IDX_W-1:0]   earlier_row,
    output logic      [IDX_W-1:0]   current_row,
    output logic                    last_of_run
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int Q_W   = $bits(cmd_t) + ROW_W;

    logic             q_full;
    logic             q_push;
    cmd_t             push_cmd;
    logic [ROW_W-1:0] push_cur;
    logic             q_pop;
    logic             head_valid;
    logic [Q_W-1:0]   head_data;
    cmd_t             head_cmd;
    logic [ROW_W-1:0] head_cur;

    psd_front #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_of_set (first_of_set),
        .class_label  (class_label),
        .signature    (signature),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd),
        .q_cur        (push_cur)
    );

    psd_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({push_cmd, push_cur}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_cmd = head_data[Q_W-1:ROW_W];
    assign head_cur = head_data[ROW_W-1:0];

    psd_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (head_valid),
        .q_cmd           (head_cmd),
        .q_cur           (head_cur),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .difference_mask (difference_mask),
        .earlier_row     (earlier_row),
        .current_row     (current_row),
        .last_of_run     (last_of_run)
    );

endmodule

`default_nettype wire

/* test/tb_pairwise_signature_difference_core.sv */
// Self-checking testbench for pairwise_signature_difference_core.
// Depends on psd_pkg and the core RTL; a scoreboard class predicts the
// difference requests of every accepted row and checks them in order.
`timescale 1ns / 1ps

module tb_pairwise_signature_difference_core;
    import psd_pkg::*;

    localparam int MAX_ROWS      = 64;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [LABEL_W-1:0] LBL_FALSE    = 3'd0;
    localparam logic [LABEL_W-1:0] LBL_TRUE     = 3'd1;
    localparam logic [LABEL_W-1:0] LBL_UNDET    = 3'd2;
    localparam logic [LABEL_W-1:0] LBL_CONFLICT = 3'd3;
    localparam logic [LABEL_W-1:0] LBL_OTHER    = 3'd4;
    localparam logic [LABEL_W-1:0] LBL_CODE5    = 3'd5;
    localparam logic [LABEL_W-1:0] LBL_CODE6    = 3'd6;
    localparam logic [LABEL_W-1:0] LBL_CODE7    = 3'd7;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [IDX_W-1:0]  earlier;
        logic [IDX_W-1:0]  current;
        logic              last;
    } pair_t;

    class psd_scoreboard;
        logic [SIG_W-1:0]   sig_store [MAX_ROWS];
        logic [LABEL_W-1:0] cls_store [MAX_ROWS];
        int unsigned        rows_kept;
        int unsigned        positions;
        pair_t              pending [$];
        int                 errors;

        function new();
            rows_kept = 0;
            positions = POS_RESET;
            errors    = 0;
        endfunction

        function void set_positions(input logic [POS_W-1:0] v);
            positions = 32'(v);
        endfunction

        function void note_row(input bit first, input logic [LABEL_W-1:0] label,
                               input logic [SIG_W-1:0] sig);
            int unsigned lim;
            int          n;
            pair_t       r;
            if (first)
                rows_kept = 0;
            if (label > LABEL_LAST_VALID || rows_kept >= MAX_ROWS)
                return;
            lim = (positions > MASK_W) ? MASK_W : positions;
            n   = 0;
            for (int e = 0; e < rows_kept; e++)
            begin
                if (cls_store[e] != label || label == LBL_CONFLICT)
                begin
                    r.mask = '0;
                    for (int p = 0; p < lim; p++)
                        r.mask[p] = (sig_store[e][2*p +: 2] != sig[2*p +: 2]);
                    r.earlier = e[IDX_W-1:0];
                    r.current = rows_kept[IDX_W-1:0];
                    r.last    = 1'b0;
                    pending.push_back(r);
                    n++;
                end
            end
            if (n > 0)
                pending[pending.size()-1].last = 1'b1;
            sig_store[rows_kept] = sig;
            cls_store[rows_kept] = label;
            rows_kept++;
        endfunction

        function void check_result(input pair_t got);
            pair_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected request: mask %h earlier %0d current %0d last %0d",
                         $time, got.mask, got.earlier, got.current, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.mask !== want.mask)
            begin
                $display("%0t: difference_mask expected %h, actual %h",
                         $time, want.mask, got.mask);
                errors++;
            end
            if (got.earlier !== want.earlier)
            begin
                $display("%0t: earlier_row expected %0d, actual %0d",
                         $time, want.earlier, got.earlier);
                errors++;
            end
            if (got.current !== want.current)
            begin
                $display("%0t: current_row expected %0d, actual %0d",
                         $time, want.current, got.current);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last_of_run expected %0d, actual %0d",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    logic [POS_W-1:0]   cfg_wr_data  = '0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               first_of_set = 1'b0;
    logic [LABEL_W-1:0] class_label  = '0;
    logic [SIG_W-1:0]   signature    = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [MASK_W-1:0]  difference_mask;
    logic [IDX_W-1:0]   earlier_row;
    logic [IDX_W-1:0]   current_row;
    logic               last_of_run;

    psd_scoreboard sb;
    bit            quiet     = 1'b0;
    bit            hold_req  = 1'b0;
    bit            hold_done = 1'b0;
    int            hold_left = 0;

    pairwise_signature_difference_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .first_of_set    (first_of_set),
        .class_label     (class_label),
        .signature       (signature),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .difference_mask (difference_mask),
        .earlier_row     (earlier_row),
        .current_row     (current_row),
        .last_of_run     (last_of_run)
    );

    always #4 clk = ~clk;

    // receiver: check accepted requests, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            sb.check_result({difference_mask, earlier_row, current_row, last_of_run});
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_ready <= quiet || ($urandom_range(99) >= 8);
    end

    task automatic send_row(input bit first, input logic [LABEL_W-1:0] label,
                            input logic [SIG_W-1:0] sig);
        while (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        first_of_set <= first;
        class_label  <= label;
        signature    <= sig;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_row(first, label, sig);
    endtask

    function automatic logic [SIG_W-1:0] make_sig(input logic [SIG_W-1:0] base);
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return base ^ {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
            2: return base;
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    function automatic logic [LABEL_W-1:0] rand_label();
        if ($urandom_range(9) == 0)
            return LABEL_W'($urandom_range(LBL_OTHER, LBL_CODE7));
        return LABEL_W'($urandom_range(LBL_FALSE, LBL_CONFLICT));
    endfunction

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_positions(input logic [POS_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_positions(v);
    endtask

    task automatic run_directed();
        send_row(1'b1, LBL_FALSE,    64'h0);
        send_row(1'b0, LBL_TRUE,     64'hFFFF_FFFF_FFFF_FFFF);
        send_row(1'b0, LBL_UNDET,    64'hAAAA_AAAA_AAAA_AAAA);
        send_row(1'b0, LBL_CONFLICT, 64'h5555_5555_5555_5555);
        send_row(1'b0, LBL_CONFLICT, 64'h0);
        send_row(1'b0, LBL_FALSE,    64'h0);
        send_row(1'b0, LBL_TRUE,     64'hFFFF_FFFF_FFFF_FFFF);
        send_row(1'b0, LBL_UNDET,    64'h8000_0000_0000_0002);
        send_row(1'b0, LBL_OTHER,    64'h0123_4567_89AB_CDEF);
        send_row(1'b0, LBL_CODE5,    64'hFFFF_FFFF_FFFF_FFFF);
        send_row(1'b0, LBL_CODE6,    64'h0);
        send_row(1'b0, LBL_CODE7,    64'hAAAA_AAAA_AAAA_AAAA);
        send_row(1'b0, LBL_FALSE,    64'hC000_0000_0000_0003);
        send_row(1'b1, LBL_OTHER,    64'h0);
        send_row(1'b0, LBL_CONFLICT, 64'hFEDC_BA98_7654_3210);
        send_row(1'b0, LBL_CONFLICT, 64'h0123_4567_89AB_CDEF);
        send_row(1'b0, LBL_UNDET,    64'hFEDC_BA98_7654_3210);
        send_row(1'b1, LBL_TRUE,     64'h5555_5555_5555_5555);
        send_row(1'b0, LBL_FALSE,    64'hAAAA_AAAA_AAAA_AAAA);
        send_row(1'b0, LBL_TRUE,     64'h0);
        in_valid <= 1'b0;
    endtask

    task automatic run_phase(input int rows_target);
        int               kept;
        int               set_len;
        bit               first;
        logic [SIG_W-1:0] base;
        logic [LABEL_W-1:0] label;
        kept = 0;
        while (kept < rows_target)
        begin
            set_len = $urandom_range(1, 12);
            base    = {$urandom, $urandom};
            first   = ($urandom_range(9) != 0);
            for (int i = 0; i < set_len; i++)
            begin
                label = rand_label();
                send_row(first, label, make_sig(base));
                if (label <= LABEL_LAST_VALID)
                    kept++;
                first = ($urandom_range(29) == 0);
            end
        end
        in_valid <= 1'b0;
    endtask

    // one set past capacity; late rows must be dropped
    task automatic fill_set(input int rows);
        logic [SIG_W-1:0] base;
        base = {$urandom, $urandom};
        for (int i = 0; i < rows; i++)
        begin
            if (i % 23 == 11)
                send_row(1'b0, LBL_OTHER, make_sig(base));
            send_row(i == 0, LABEL_W'($urandom_range(LBL_FALSE, LBL_CONFLICT)),
                     make_sig(base));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        run_directed();

        wait_drained();
        write_positions(6'd0);
        run_phase(10);

        wait_drained();
        write_positions(6'd1);
        run_phase(10);

        wait_drained();
        write_positions(6'd33);
        run_phase(10);

        wait_drained();
        write_positions(6'd63);
        quiet = 1'b1;
        run_phase(10);
        quiet = 1'b0;

        wait_drained();
        write_positions(6'd32);
        hold_req = 1'b1;
        fill_set(66);
        run_phase(5);

        wait_drained();
        write_positions(6'd17);
        run_phase(10);

        wait_drained();
        write_positions(POS_W'($urandom_range(1, 32)));
        run_phase(10);

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_pairwise_signature_difference_core passed");
        else
            $display("tb_pairwise_signature_difference_core failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("tb_pairwise_signature_difference_core failed");
        $finish;
    end

endmodule

/* sim.f */
src/psd_pkg.sv
src/psd_ram.sv
src/psd_queue.sv
src/psd_front.sv
src/psd_back.sv
src/pairwise_signature_difference_core.sv
test/tb_pairwise_signature_difference_core.sv
